FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the steering block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define LFS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lfs assertion failed");

// Property checked at every rising edge, reset included.
`define LFS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lfs assertion failed");

`endif

FILE: rtl/core/lfs_pkg.sv
// Package of the line follow steering block: types, constants and helpers.
// Depends on nothing; used by the interfaces and every module.
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

  localparam int SENSOR_W = 8;
  localparam int SPEED_W  = 16;
  localparam int CFG_IDX_W = 4;
  localparam int SUM_W    = SPEED_W + 2;
  localparam int STEP_W   = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_MIN    = 4'd0,
    CFG_SPEED_MAX    = 4'd1,
    CFG_CENTER_SPEED = 4'd2,
    CFG_PWM_PERIOD   = 4'd3
  } cfg_idx_t;

  localparam logic [SPEED_W-1:0] RST_SPEED_MIN    = 16'd35000;
  localparam logic [SPEED_W-1:0] RST_SPEED_MAX    = 16'd50000;
  localparam logic [SPEED_W-1:0] RST_CENTER_SPEED = 16'd40000;
  localparam logic [SPEED_W-1:0] RST_PWM_PERIOD   = 16'd64000;
  localparam logic [SPEED_W-1:0] RST_MOTOR_SPEED  = 16'd46000;

  localparam logic signed [STEP_W-1:0] STEP_S1_R = -14'sd6000;
  localparam logic signed [STEP_W-1:0] STEP_S1_L = 14'sd4000;
  localparam logic signed [STEP_W-1:0] STEP_S2_R = -14'sd5000;
  localparam logic signed [STEP_W-1:0] STEP_S2_L = 14'sd3000;
  localparam logic signed [STEP_W-1:0] STEP_S3_R = -14'sd4000;
  localparam logic signed [STEP_W-1:0] STEP_S3_L = 14'sd2000;
  localparam logic signed [STEP_W-1:0] STEP_S6_R = 14'sd2000;
  localparam logic signed [STEP_W-1:0] STEP_S6_L = -14'sd2000;
  localparam logic signed [STEP_W-1:0] STEP_S7_R = 14'sd3000;
  localparam logic signed [STEP_W-1:0] STEP_S7_L = -14'sd3000;
  localparam logic signed [STEP_W-1:0] STEP_S8_R = 14'sd4000;
  localparam logic signed [STEP_W-1:0] STEP_S8_L = -14'sd4000;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_min;
    logic [SPEED_W-1:0] speed_max;
    logic [SPEED_W-1:0] center_speed;
    logic [SPEED_W-1:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [SENSOR_W-1:0]   sensor_levels;
  } in_stage_t;

  typedef struct packed {
    logic                      load_center;
    logic signed [STEP_W-1:0]  right_step;
    logic signed [STEP_W-1:0]  left_step;
  } step_t;

  // Sensors are active low; the first active one in the order 1, 2, 3, 6, 7, 8 wins.
  function automatic step_t select_step(input logic [SENSOR_W-1:0] levels);
    step_t st;
    st = '0;
    if (!levels[0]) begin
      st.right_step = STEP_S1_R;
      st.left_step  = STEP_S1_L;
    end else if (!levels[1]) begin
      st.right_step = STEP_S2_R;
      st.left_step  = STEP_S2_L;
    end else if (!levels[2]) begin
      st.right_step = STEP_S3_R;
      st.left_step  = STEP_S3_L;
    end else if (!levels[5]) begin
      st.right_step = STEP_S6_R;
      st.left_step  = STEP_S6_L;
    end else if (!levels[6]) begin
      st.right_step = STEP_S7_R;
      st.left_step  = STEP_S7_L;
    end else if (!levels[7]) begin
      st.right_step = STEP_S8_R;
      st.left_step  = STEP_S8_L;
    end else if (!levels[3] && !levels[4]) begin
      st.load_center = 1'b1;
    end
    return st;
  endfunction

  // The lower clamp comes first, so the upper clamp wins when they cross.
  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic signed [SUM_W-1:0] sum,
    input logic [SPEED_W-1:0]      lo,
    input logic [SPEED_W-1:0]      hi
  );
    logic signed [SUM_W-1:0] v;
    v = sum;
    if (v < $signed({2'b00, lo})) begin
      v = $signed({2'b00, lo});
    end
    if (v >= $signed({2'b00, hi})) begin
      v = $signed({2'b00, hi});
    end
    return v[SPEED_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] limit_compare(
    input logic [SPEED_W-1:0] speed,
    input logic [SPEED_W-1:0] period
  );
    logic [SPEED_W-1:0] lim;
    lim = (period >= 16'd2) ? period - 16'd2 : '0;
    return (speed > lim) ? lim : speed;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lfs_intf.sv
// Request channel interfaces of the steering block: sensor input, compare
// output and register write. Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lfs_in_if import lfs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_levels;
  modport source (output valid, output sensor_levels, input ready);
  modport sink (input valid, input sensor_levels, output ready);
endinterface

interface lfs_out_if import lfs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] right_compare;
  logic [SPEED_W-1:0] left_compare;
  modport source (output valid, output right_compare, output left_compare, input ready);
  modport sink (input valid, input right_compare, input left_compare, output ready);
endinterface

interface lfs_cfg_if import lfs_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SPEED_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lfs_cfg_regs.sv
// Configuration registers of the steering block, written through the
// register write channel. Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfs_cfg_regs import lfs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPEED_W-1:0]   cfg_data,
  output logic                 cfg_ready,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPEED_MIN:    cfg_nxt.speed_min    = cfg_data;
        CFG_SPEED_MAX:    cfg_nxt.speed_max    = cfg_data;
        CFG_CENTER_SPEED: cfg_nxt.center_speed = cfg_data;
        CFG_PWM_PERIOD:   cfg_nxt.pwm_period   = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_min    <= RST_SPEED_MIN;
      cfg_r.speed_max    <= RST_SPEED_MAX;
      cfg_r.center_speed <= RST_CENTER_SPEED;
      cfg_r.pwm_period   <= RST_PWM_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lfs_in_stage.sv
// Input register of the steering block; holds one sensor request until the
// speed stage takes it. Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfs_in_stage import lfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [SENSOR_W-1:0] in_sensor_levels,
  output logic                in_ready,
  input  logic                advance,
  output in_stage_t           stage
);

  logic                valid_r;
  logic                valid_nxt;
  logic [SENSOR_W-1:0] sensor_r;

  assign in_ready = !valid_r || advance;
  assign stage    = '{valid: valid_r, sensor_levels: sensor_r};

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sensor_r <= in_sensor_levels;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lfs_steer_core.sv
// Speed stage of the steering block: kept motor speeds, step selection,
// clamping and the registered compare outputs. Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfs_steer_core import lfs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  in_stage_t          stage,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SPEED_W-1:0] out_right_compare,
  output logic [SPEED_W-1:0] out_left_compare
);

  logic               out_valid_r;
  logic [SPEED_W-1:0] right_speed_r;
  logic [SPEED_W-1:0] left_speed_r;
  logic [SPEED_W-1:0] right_cmp_r;
  logic [SPEED_W-1:0] left_cmp_r;

  step_t                   step;
  logic signed [SUM_W-1:0] right_sum;
  logic signed [SUM_W-1:0] left_sum;
  logic [SPEED_W-1:0]      right_speed_nxt;
  logic [SPEED_W-1:0]      left_speed_nxt;
  logic                    take;

  assign advance           = !out_valid_r || out_ready;
  assign take              = advance && stage.valid;
  assign out_valid         = out_valid_r;
  assign out_right_compare = right_cmp_r;
  assign out_left_compare  = left_cmp_r;

  always_comb begin
    step = select_step(stage.sensor_levels);
    if (step.load_center) begin
      right_sum = $signed({2'b00, cfg.center_speed});
      left_sum  = $signed({2'b00, cfg.center_speed});
    end else begin
      right_sum = $signed({2'b00, right_speed_r}) + SUM_W'(step.right_step);
      left_sum  = $signed({2'b00, left_speed_r}) + SUM_W'(step.left_step);
    end
    right_speed_nxt = clamp_speed(right_sum, cfg.speed_min, cfg.speed_max);
    left_speed_nxt  = clamp_speed(left_sum, cfg.speed_min, cfg.speed_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      right_speed_r <= RST_MOTOR_SPEED;
      left_speed_r  <= RST_MOTOR_SPEED;
    end else begin
      if (advance) begin
        out_valid_r <= stage.valid;
      end
      if (take) begin
        right_speed_r <= right_speed_nxt;
        left_speed_r  <= left_speed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      right_cmp_r <= limit_compare(right_speed_nxt, cfg.pwm_period);
      left_cmp_r  <= limit_compare(left_speed_nxt, cfg.pwm_period);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/line_follow_steering.sv
// A request goes through the input register and then the output register.
// Throughput: one request per cycle unless the output stalls; the output and
// input registers let a new request enter while a result waits to be taken.
// Reset (rst_n low, synchronous) empties both stages, loads the register
// defaults and sets both kept motor speeds to 46000.
// Top level of the steering block; depends on lfs_pkg, the interfaces,
// lfs_cfg_regs, lfs_in_stage and lfs_steer_core.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_steering import lfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lfs_in_if.sink     in_chan,
  lfs_out_if.source  out_chan,
  lfs_cfg_if.sink    cfg_chan
);

  cfg_t      cfg;
  in_stage_t stage;
  logic      advance;

  lfs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .cfg_ready (cfg_chan.ready),
    .cfg       (cfg)
  );

  lfs_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_sensor_levels (in_chan.sensor_levels),
    .in_ready         (in_chan.ready),
    .advance          (advance),
    .stage            (stage)
  );

  lfs_steer_core u_steer_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .stage             (stage),
    .advance           (advance),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_right_compare (out_chan.right_compare),
    .out_left_compare  (out_chan.left_compare)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lfs_checker.sv
// Port checker of the steering block and its bind to the top level.
// Depends on lfs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lfs_checker import lfs_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [SPEED_W-1:0] right_compare,
  input wire logic [SPEED_W-1:0] left_compare,
  input wire logic               cfg_ready
);

  `LFS_ASSERT_ALWAYS(a_out_empty_after_reset, clk, !rst_n |=> !out_valid)
  `LFS_ASSERT(a_in_ready_when_out_empty, clk, rst_n, !out_valid |-> in_ready)
  `LFS_ASSERT(a_out_held_on_stall, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `LFS_ASSERT(a_out_stable_on_stall, clk, rst_n,
    out_valid && !out_ready |=> $stable(right_compare) && $stable(left_compare))
  `LFS_ASSERT(a_cfg_always_ready, clk, rst_n, cfg_ready)

endmodule

bind line_follow_steering lfs_checker u_lfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .right_compare (out_chan.right_compare),
  .left_compare  (out_chan.left_compare),
  .cfg_ready     (cfg_chan.ready)
);

`default_nettype wire

FILE: test/line_follow_steering_tb.sv
// Self-checking testbench of line_follow_steering: sensor requests, register
// writes and PWM compare results checked against an in-bench speed model.
// Depends on lfs_pkg, the lfs interfaces and the line_follow_steering RTL.
`timescale 1ns / 1ps

module line_follow_steering_tb import lfs_pkg::*;;

  localparam int IDLE_LIMIT = 500;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 55;
  localparam int WIN_ORDER [6] = '{0, 1, 2, 5, 6, 7};

  typedef struct packed {
    logic [SPEED_W-1:0] right_compare;
    logic [SPEED_W-1:0] left_compare;
  } compare_pair_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] levels;
    logic [3:0]          gap;
    logic                drain;
  } sensor_req_t;

  logic clk = 1'b0;
  logic rst_n;

  lfs_in_if  in_bus();
  lfs_out_if out_bus();
  lfs_cfg_if cfg_bus();

  line_follow_steering dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register and speed state as the block should hold it.
  int cur_speed_min;
  int cur_speed_max;
  int cur_center;
  int cur_period;
  int kept_right;
  int kept_left;

  sensor_req_t   sensor_q[$];
  compare_pair_t compare_q[$];

  int  queued_total;
  int  sent_count;
  int  out_count;
  int  gap_cnt;
  int  stall_cnt;
  int  stall_next;
  int  hold_cnt;
  int  idle_cycles;
  int  errors;
  bit  send_fast;
  bit  take_fast;
  logic long_hold_req;
  logic long_hold_done;
  compare_pair_t want;

  function automatic int bound_speed(input int v);
    if (v < cur_speed_min) begin
      v = cur_speed_min;
    end
    if (v >= cur_speed_max) begin
      v = cur_speed_max;
    end
    return v;
  endfunction

  function automatic compare_pair_t next_compares(input logic [SENSOR_W-1:0] levels);
    int r;
    int l;
    int lim;
    compare_pair_t res;
    r = kept_right;
    l = kept_left;
    if (!levels[0]) begin
      r -= 6000;
      l += 4000;
    end else if (!levels[1]) begin
      r -= 5000;
      l += 3000;
    end else if (!levels[2]) begin
      r -= 4000;
      l += 2000;
    end else if (!levels[5]) begin
      r += 2000;
      l -= 2000;
    end else if (!levels[6]) begin
      r += 3000;
      l -= 3000;
    end else if (!levels[7]) begin
      r += 4000;
      l -= 4000;
    end else if (!levels[3] && !levels[4]) begin
      r = cur_center;
      l = cur_center;
    end
    kept_right = bound_speed(r) & 16'hFFFF;
    kept_left  = bound_speed(l) & 16'hFFFF;
    lim = (cur_period >= 2) ? cur_period - 2 : 0;
    res.right_compare = 16'((kept_right > lim) ? lim : kept_right);
    res.left_compare  = 16'((kept_left > lim) ? lim : kept_left);
    return res;
  endfunction

  task automatic set_steer_reg(input cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= 16'(value);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_SPEED_MIN:    cur_speed_min = value;
      CFG_SPEED_MAX:    cur_speed_max = value;
      CFG_CENTER_SPEED: cur_center = value;
      CFG_PWM_PERIOD:   cur_period = value;
      default: ;
    endcase
  endtask

  task automatic queue_sensor(input logic [SENSOR_W-1:0] levels, input bit drain);
    sensor_req_t req;
    req.levels = levels;
    req.gap    = send_fast ? 4'd0 : 4'($urandom_range(0, 9));
    req.drain  = drain;
    sensor_q.push_back(req);
    queued_total++;
  endtask

  task automatic finish_phase();
    @(posedge clk);
    while (out_count != queued_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sensor request driver. A drain request waits until every result is back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid         <= 1'b0;
      in_bus.sensor_levels <= '0;
      gap_cnt              <= 0;
      sent_count           <= 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (sensor_q.size() != 0 && gap_cnt < sensor_q[0].gap) begin
        gap_cnt      <= gap_cnt + 1;
        in_bus.valid <= 1'b0;
      end else if (sensor_q.size() != 0 &&
                   (!sensor_q[0].drain || (!in_bus.valid && out_count == sent_count))) begin
        in_bus.sensor_levels <= sensor_q[0].levels;
        in_bus.valid         <= 1'b1;
        void'(sensor_q.pop_front());
        gap_cnt    <= 0;
        sent_count <= sent_count + 1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result monitor: predicts on each accepted sensor request, checks each
  // accepted result and drives ready with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready  <= 1'b0;
      stall_cnt      <= 0;
      hold_cnt       <= 0;
      out_count      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        compare_q.push_back(next_compares(in_bus.sensor_levels));
      end
      if (out_bus.valid && out_bus.ready) begin
        out_count <= out_count + 1;
        if (compare_q.size() == 0) begin
          $error("result with nothing expected: right_compare %0d left_compare %0d",
                 out_bus.right_compare, out_bus.left_compare);
          errors++;
        end else begin
          want = compare_q.pop_front();
          if (out_bus.right_compare !== want.right_compare) begin
            $error("right_compare expected %0d actual %0d",
                   want.right_compare, out_bus.right_compare);
            errors++;
          end
          if (out_bus.left_compare !== want.left_compare) begin
            $error("left_compare expected %0d actual %0d",
                   want.left_compare, out_bus.left_compare);
            errors++;
          end
        end
        stall_next = take_fast ? 0 : $urandom_range(0, 9);
      end else begin
        stall_next = (stall_cnt > 0) ? stall_cnt - 1 : 0;
      end
      stall_cnt <= stall_next;
      if (long_hold_req && !long_hold_done) begin
        hold_cnt       <= LONG_HOLD_CYCLES;
        long_hold_done <= 1'b1;
        out_bus.ready  <= 1'b0;
      end else begin
        if (hold_cnt > 0) begin
          hold_cnt <= hold_cnt - 1;
        end
        out_bus.ready <= (hold_cnt <= 1) && (stall_next == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[line_follow_steering] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    int n;
    int kind;
    int k;
    int j;
    int rmin;
    int rmax;
    int rctr;
    int rper;
    logic [SENSOR_W-1:0] lv;

    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.sensor_levels = '0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    long_hold_req        = 1'b0;
    idle_cycles          = 0;
    errors               = 0;
    queued_total         = 0;
    send_fast            = 1'b0;
    take_fast            = 1'b0;
    cur_speed_min        = RST_SPEED_MIN;
    cur_speed_max        = RST_SPEED_MAX;
    cur_center           = RST_CENTER_SPEED;
    cur_period           = RST_PWM_PERIOD;
    kept_right           = RST_MOTOR_SPEED;
    kept_left            = RST_MOTOR_SPEED;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: no sensor, all sensors, each sensor alone, both
    // center sensors, and center sensors losing to sensor 1.
    queue_sensor(8'hFF, 1'b0);
    queue_sensor(8'h00, 1'b0);
    queue_sensor(8'hFE, 1'b0);
    queue_sensor(8'hFD, 1'b0);
    queue_sensor(8'hFB, 1'b0);
    queue_sensor(8'hF7, 1'b0);
    queue_sensor(8'hEF, 1'b0);
    queue_sensor(8'hDF, 1'b0);
    queue_sensor(8'hBF, 1'b0);
    queue_sensor(8'h7F, 1'b0);
    queue_sensor(8'hE7, 1'b0);
    queue_sensor(8'hE6, 1'b0);
    finish_phase();

    // Full range: the left sum passes 65535 and the right sum goes negative.
    set_steer_reg(CFG_SPEED_MIN, 0);
    set_steer_reg(CFG_SPEED_MAX, 65535);
    set_steer_reg(CFG_CENTER_SPEED, 65535);
    set_steer_reg(CFG_PWM_PERIOD, 65535);
    queue_sensor(8'hE7, 1'b0);
    for (n = 0; n < 11; n++) begin
      queue_sensor(8'hFE, 1'b0);
    end
    queue_sensor(8'h7F, 1'b0);
    finish_phase();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      rmin = $urandom_range(20000, 40000);
      rmax = $urandom_range(40000, 65535);
      rctr = $urandom_range(0, 65535);
      rper = $urandom_range(30000, 65535);
      case (p)
        0: begin
          rmin = 20000;
          rmax = 60000;
          rctr = 30000;
          rper = 65535;
        end
        2: begin
          rmin = 60000;
          rmax = 30000;
        end
        3: rper = 0;
        4: rper = 1;
        5: rper = 2;
        6: begin
          rmin = 0;
          rmax = 0;
          rctr = 0;
        end
        7: begin
          rmin = 65535;
          rmax = 65535;
          rctr = 65535;
          rper = 65535;
        end
        8, 9: begin
          rmin = $urandom_range(0, 65535);
          rmax = $urandom_range(0, 65535);
          rper = $urandom_range(0, 65535);
        end
        default: ;
      endcase
      set_steer_reg(CFG_SPEED_MIN, rmin);
      set_steer_reg(CFG_SPEED_MAX, rmax);
      set_steer_reg(CFG_CENTER_SPEED, rctr);
      set_steer_reg(CFG_PWM_PERIOD, rper);
      send_fast = (p == 1) || (p == 9);
      take_fast = (p == 9);
      if (p == 1) begin
        long_hold_req <= 1'b1;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 99);
        lv = SENSOR_W'($urandom());
        if (kind < 20) begin
        end else if (kind < 35) begin
          lv = 8'hFF;
        end else if (kind < 50) begin
          case ($urandom_range(0, 3))
            0: lv = 8'hF7;
            1: lv = 8'hEF;
            default: lv = 8'hE7;
          endcase
        end else begin
          k = $urandom_range(0, 5);
          for (j = 0; j < k; j++) begin
            lv[WIN_ORDER[j]] = 1'b1;
          end
          lv[WIN_ORDER[k]] = 1'b0;
        end
        queue_sensor(lv, (p == 3 && n == 20) || ($urandom_range(0, 49) == 0));
      end
      finish_phase();
    end

    if (compare_q.size() != 0) begin
      $error("%0d expected results never arrived", compare_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[line_follow_steering] OK");
    end else begin
      $display("[line_follow_steering] ERROR");
    end
    $finish;
  end

endmodule
